// ===== sv/gaussian_function_eval_top_defines.svh =====
// Assertion macros for the gaussian evaluator.
// Bodies sample on clk and are disabled while rst is high.
`ifndef GAUSSIAN_FUNCTION_EVAL_TOP_DEFINES_SVH
`define GAUSSIAN_FUNCTION_EVAL_TOP_DEFINES_SVH

// Same-cycle implication
`define GFE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gfe_pkg.sv =====
// Shared types, constants and elaboration-time functions for the gaussian evaluator.
// No dependencies.
package gfe_pkg;

  localparam int FRAC_BITS_DEF      = 16;
  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam int RATIO_BITS         = 28;
  localparam int QUO_BITS           = 31;
  localparam int REM_W              = 35;
  localparam int SERIES_TERMS       = 12;
  localparam int RECIP_SHIFT        = 34;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  // Register indexes
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_AMPLITUDE = 2'd0;
  localparam reg_index_t REG_CENTER    = 2'd1;
  localparam reg_index_t REG_WIDTH     = 2'd2;

  localparam logic [31:0] AMPLITUDE_RESET = 32'h0001_0000;
  localparam logic [31:0] CENTER_RESET    = 32'h0000_0000;
  localparam logic [31:0] WIDTH_RESET     = 32'h0001_0000;

  // Sideband through the divider
  typedef struct packed {
    logic zero;
    logic far;
  } div_tag_t;

  // Sideband through the series
  typedef struct packed {
    logic        zero;
    logic        far;
    logic [5:0]  k;
    logic [30:0] tbl;
  } exp_tag_t;

  // ceil(2^34 / n): exact truncating division for dividends below 2^30
  function automatic logic [34:0] recip_m(input int n);
    case (n)
      1:       return 35'd17179869184;
      2:       return 35'd8589934592;
      3:       return 35'd5726623062;
      4:       return 35'd4294967296;
      5:       return 35'd3435973837;
      6:       return 35'd2863311531;
      7:       return 35'd2454267027;
      8:       return 35'd2147483648;
      9:       return 35'd1908874354;
      10:      return 35'd1717986919;
      11:      return 35'd1561806290;
      12:      return 35'd1431655766;
      default: return '0;
    endcase
  endfunction

  // e^-z, z and result in Q30, truncated Taylor series
  function automatic logic [30:0] exp_neg_q30(input logic [29:0] z);
    logic signed [63:0] sum;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic [71:0]        wide;
    sum  = 64'sd1073741824;
    term = 64'(ONE_Q30);
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      prod = (term * 64'(z)) >> 30;
      wide = 72'(prod) * 72'(recip_m(n));
      term = 64'(wide >> RECIP_SHIFT);
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return sum[30:0];
  endfunction

  // 2^-v for v with RATIO_BITS fraction bits
  function automatic logic [30:0] exp2_neg_frac(input logic [RATIO_BITS-1:0] v);
    logic [63:0] zsum;
    zsum = 64'(v) * 64'(LN2_Q30) + (64'd1 << (RATIO_BITS - 1));
    return exp_neg_q30(zsum[57:28]);
  endfunction

endpackage

// ===== sv/gfe_ifaces.sv =====
// Valid/ready channel interfaces for samples and results.
// Depends on nothing.
interface gfe_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_x;

  modport source (output valid, output sample_x, input ready);
  modport sink (input valid, input sample_x, output ready);
endinterface

interface gfe_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_y;
  logic        width_zero;

  modport source (output valid, output value_y, output width_zero, input ready);
  modport sink (input valid, input value_y, input width_zero, output ready);
endinterface

// ===== sv/gaussian_function_eval_top.sv =====
// Gaussian evaluator y = a*exp(-(x-b)^2/(2c^2)), Q16.16, top level.
// The pipe from sample word accepted to result word valid is mostly the
// 31-stage divider and the 24-stage series.
// Throughput one word per cycle; the whole pipe holds when the output stalls.
// Synchronous reset clears valid bits and loads a=1.0, b=0, c=1.0.
// Depends on gfe_pkg, gfe_ifaces, gfe_div, gfe_series and the defines header.
`include "gaussian_function_eval_top_defines.svh"

module gaussian_function_eval_top
  import gfe_pkg::*;
#(
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  reg_index_t  wr_index,
  input  logic [31:0] wr_data,
  gfe_sample_if.sink  sample,
  gfe_result_if.source result
);

  localparam int TBL_SIZE = 1 << EXP_TABLE_BITS;
  localparam int REM_BITS = RATIO_BITS - EXP_TABLE_BITS;
  localparam int E_W      = FRAC_BITS + 1;
  localparam int PROD_W   = 32 + E_W;
  localparam int SH_BASE  = 29 - FRAC_BITS;

  typedef logic [30:0] exp_tbl_t [TBL_SIZE];

  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t tbl;
    for (int j = 0; j < TBL_SIZE; j++) begin
      tbl[j] = exp2_neg_frac(RATIO_BITS'(j) << REM_BITS);
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  // Configuration registers
  logic signed [31:0] amplitude;
  logic [31:0]        center;
  logic [31:0]        width;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMPLITUDE_RESET;
      center    <= CENTER_RESET;
      width     <= WIDTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_AMPLITUDE: amplitude <= wr_data;
        REG_CENTER:    center    <= wr_data;
        REG_WIDTH:     width     <= wr_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic res_valid;
  logic [31:0] res_y;
  logic res_zero;

  // Advance the whole pipe unless the output word is stuck
  assign en           = !res_valid || result.ready;
  assign sample.ready = en;

  // Stage 1: difference at full width
  logic               v1;
  logic signed [32:0] d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= $signed({sample.sample_x[31], sample.sample_x}) - $signed({center[31], center});
    end
  end

  // Stage 2: magnitude and range checks
  logic [32:0]      m_abs;
  logic [REM_W-1:0] den;
  logic             far_c;
  logic             v2;
  logic [32:0]      m2;
  div_tag_t         tag2;

  assign m_abs = d1[32] ? 33'(-d1) : 33'(d1);
  assign den   = {width, 3'b000};
  assign far_c = (width == '0) || ({2'b00, m_abs} >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2        <= m_abs;
      tag2.zero <= (width == '0);
      tag2.far  <= far_c;
    end
  end

  // Ratio |d|/c in Q28
  logic                v_dv;
  logic [QUO_BITS-1:0] r_dv;
  div_tag_t            tag_dv;

  gfe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_rem    (tag2.far ? '0 : {2'b00, m2}),
    .in_den    (den),
    .in_tag    (tag2),
    .out_valid (v_dv),
    .out_quo   (r_dv),
    .out_tag   (tag_dv)
  );

  // Stage 3: t = r^2 / 2
  logic [61:0] rsq;
  logic        v3;
  logic [32:0] t3;
  div_tag_t    tag3;

  assign rsq = 62'(r_dv) * 62'(r_dv);

  // Stage 4: scale by log2(e), split integer and fraction
  logic [63:0]           ut;
  logic                  v4;
  logic [5:0]            k4;
  logic [RATIO_BITS-1:0] f4;
  div_tag_t              tag4;

  assign ut = 64'(t3) * 64'(LOG2E_Q30) + (64'd1 << 29);

  // Stage 5: table lookup and series argument
  logic [63:0] zsum;
  logic        v5;
  logic [29:0] z5;
  exp_tag_t    tag5;

  assign zsum = 64'(f4[REM_BITS-1:0]) * 64'(LN2_Q30) + (64'd1 << (RATIO_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v3 <= v_dv;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3        <= rsq[61:29];
      tag3      <= tag_dv;
      k4        <= ut[63:58];
      f4        <= ut[57:30];
      tag4      <= tag3;
      z5        <= zsum[57:28];
      tag5.zero <= tag4.zero;
      tag5.far  <= tag4.far;
      tag5.k    <= k4;
      tag5.tbl  <= EXP_TBL[f4[RATIO_BITS-1 -: EXP_TABLE_BITS]];
    end
  end

  // Series for the low fraction bits
  logic        v_sr;
  logic [30:0] g_sr;
  exp_tag_t    tag_sr;

  gfe_series u_series (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_z      (z5),
    .in_tag    (tag5),
    .out_valid (v_sr),
    .out_g     (g_sr),
    .out_tag   (tag_sr)
  );

  // Stage 6: combine table and series
  logic [63:0] psum;
  logic        v6;
  logic [30:0] p6;
  logic [5:0]  k6;
  logic        zero6;
  logic        far6;

  assign psum = 64'(tag_sr.tbl) * 64'(g_sr) + (64'd1 << 29);

  // Stage 7: apply 2^-k and round to FRAC_BITS
  logic [6:0]     sh_m1;
  logic [31:0]    shifted;
  logic [31:0]    e_round;
  logic           v7;
  logic [E_W-1:0] e7;
  logic           zero7;

  assign sh_m1   = 7'(SH_BASE) + 7'(k6);
  assign shifted = (sh_m1 >= 7'd31) ? '0 : (32'(p6) >> sh_m1[4:0]);
  assign e_round = (shifted + 32'd1) >> 1;

  // Stage 8: amplitude product in sign-magnitude form
  logic [31:0]       amag;
  logic              v8;
  logic [PROD_W-1:0] prod8;
  logic              neg8;
  logic              zero8;

  assign amag = amplitude[31] ? 32'(-amplitude) : 32'(amplitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v6 <= v_sr;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6    <= psum[60:30];
      k6    <= tag_sr.k;
      zero6 <= tag_sr.zero;
      far6  <= tag_sr.far;
      e7    <= far6 ? '0 : E_W'(e_round);
      zero7 <= zero6;
      prod8 <= PROD_W'(amag) * PROD_W'(e7);
      neg8  <= amplitude[31];
      zero8 <= zero7;
    end
  end

  // Output stage: round half away from zero, saturate
  logic [PROD_W-1:0] rsum;
  logic [32:0]       mag;
  logic [31:0]       y_c;

  assign rsum = prod8 + (PROD_W'(1) << (FRAC_BITS - 1));
  assign mag  = rsum[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (!neg8) begin
      y_c = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      y_c = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_y    <= y_c;
      res_zero <= zero8;
    end
  end

  assign result.valid      = res_valid;
  assign result.value_y    = res_y;
  assign result.width_zero = res_zero;

  // Checks
  `GFE_ASSERT_IMPLY(a_zero_width_value, result.valid && result.width_zero, result.value_y == '0, "zero width gave a nonzero value")
  `GFE_ASSERT_IMPLY(a_exp_bound, v7, e7 <= (E_W'(1) << FRAC_BITS), "exponential above one")
  `GFE_ASSERT_NEXT(a_last_stage_moves, v8 && en, result.valid, "word lost at output stage")

endmodule

// ===== sv/gfe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on gfe_pkg.
module gfe_div
  import gfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [REM_W-1:0]    in_rem,
  input  logic [REM_W-1:0]    in_den,
  input  div_tag_t            in_tag,
  output logic                out_valid,
  output logic [QUO_BITS-1:0] out_quo,
  output div_tag_t            out_tag
);

  logic [REM_W-1:0]    rem [QUO_BITS];
  logic [QUO_BITS-1:0] quo [QUO_BITS];
  div_tag_t            tag [QUO_BITS];
  logic                vld [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    logic [REM_W-1:0]    rem_src;
    logic [QUO_BITS-1:0] quo_src;
    div_tag_t            tag_src;
    logic                vld_src;
    logic [REM_W:0]      dbl;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_src = in_rem;
      assign quo_src = '0;
      assign tag_src = in_tag;
      assign vld_src = in_valid;
    end else begin : g_rest
      assign rem_src = rem[i-1];
      assign quo_src = quo[i-1];
      assign tag_src = tag[i-1];
      assign vld_src = vld[i-1];
    end

    // Double the remainder, subtract the divisor when it fits
    assign dbl = {rem_src, 1'b0};
    assign ge  = dbl >= {1'b0, in_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? REM_W'(dbl - {1'b0, in_den}) : REM_W'(dbl);
        quo[i] <= {quo_src[QUO_BITS-2:0], ge};
        tag[i] <= tag_src;
      end
    end
  end

  assign out_valid = vld[QUO_BITS-1];
  assign out_quo   = quo[QUO_BITS-1];
  assign out_tag   = tag[QUO_BITS-1];

endmodule

// ===== sv/gfe_series.sv =====
// Pipelined Taylor series for e^-z in Q30, two stages per term.
// Depends on gfe_pkg.
module gfe_series
  import gfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [29:0] in_z,
  input  exp_tag_t    in_tag,
  output logic        out_valid,
  output logic [30:0] out_g,
  output exp_tag_t    out_tag
);

  // Stage A: product term*z >> 30
  logic [29:0]        a_p   [SERIES_TERMS];
  logic signed [31:0] a_sum [SERIES_TERMS];
  logic [29:0]        a_z   [SERIES_TERMS];
  exp_tag_t           a_tag [SERIES_TERMS];
  logic               a_v   [SERIES_TERMS];
  // Stage B: divide by the term number, accumulate
  logic [30:0]        b_term [SERIES_TERMS];
  logic signed [31:0] b_sum  [SERIES_TERMS];
  logic [29:0]        b_z    [SERIES_TERMS];
  exp_tag_t           b_tag  [SERIES_TERMS];
  logic               b_v    [SERIES_TERMS];

  for (genvar n = 0; n < SERIES_TERMS; n++) begin : g_term
    localparam logic [34:0] RECIP    = recip_m(n + 1);
    localparam bit          SUBTRACT = ((n % 2) == 0);

    logic [30:0]        term_src;
    logic signed [31:0] sum_src;
    logic [29:0]        z_src;
    exp_tag_t           tag_src;
    logic               v_src;
    logic [60:0]        tz;
    logic [64:0]        pm;

    if (n == 0) begin : g_first
      assign term_src = ONE_Q30;
      assign sum_src  = $signed(32'(ONE_Q30));
      assign z_src    = in_z;
      assign tag_src  = in_tag;
      assign v_src    = in_valid;
    end else begin : g_rest
      assign term_src = b_term[n-1];
      assign sum_src  = b_sum[n-1];
      assign z_src    = b_z[n-1];
      assign tag_src  = b_tag[n-1];
      assign v_src    = b_v[n-1];
    end

    assign tz = 61'(term_src) * 61'(z_src);
    assign pm = 65'(a_p[n]) * 65'(RECIP);

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[n] <= 1'b0;
        b_v[n] <= 1'b0;
      end else if (en) begin
        a_v[n] <= v_src;
        b_v[n] <= a_v[n];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_p[n]    <= tz[59:30];
        a_sum[n]  <= sum_src;
        a_z[n]    <= z_src;
        a_tag[n]  <= tag_src;
        b_term[n] <= pm[64:34];
        b_z[n]    <= a_z[n];
        b_tag[n]  <= a_tag[n];
        if (SUBTRACT) begin
          b_sum[n] <= a_sum[n] - $signed(32'(pm[64:34]));
        end else begin
          b_sum[n] <= a_sum[n] + $signed(32'(pm[64:34]));
        end
      end
    end
  end

  // Clamp a negative sum to zero
  assign out_valid = b_v[SERIES_TERMS-1];
  assign out_tag   = b_tag[SERIES_TERMS-1];
  assign out_g     = b_sum[SERIES_TERMS-1][31] ? '0 : b_sum[SERIES_TERMS-1][30:0];

endmodule

// ===== test/tb_gaussian_function_eval_top.sv =====
// Testbench for the gaussian evaluator: random and directed sample words, a predictor
// computing y = a*exp(-(x-b)^2/(2c^2)) in Q16.16, and a scoreboard of expected results.
// Depends on gfe_pkg, gfe_ifaces and gaussian_function_eval_top.
`timescale 1ns / 100ps

module tb_gaussian_function_eval_top
  import gfe_pkg::*;
;

  localparam int FRAC = 16;
  localparam int TBITS = 8;
  localparam int RBITS = 28;
  localparam int QBITS = RBITS - TBITS;
  localparam logic [63:0] LOG2E = 64'd1549082005;
  localparam logic [63:0] LN2 = 64'd744261118;
  localparam int LATENCY = 64;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] value_y;
    logic        width_zero;
  } gauss_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  reg_index_t wr_index = REG_AMPLITUDE;
  logic [31:0] wr_data = '0;

  gfe_sample_if sample ();
  gfe_result_if result ();

  gaussian_function_eval_top dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .sample(sample.sink), .result(result.source)
  );

  always #1 clk = ~clk;

  // Predictor state: shadow registers and the 2^-f table
  logic signed [31:0] amp_q = 32'sh0001_0000;
  logic signed [31:0] ctr_q = 0;
  logic [31:0] wid_q = 32'h0001_0000;
  logic [63:0] pow2_lut [0:(1<<TBITS)-1];

  logic [31:0]   sample_words [$];
  gauss_result_t expected_results [$];
  int  send_idle_pct = 11;
  int  recv_idle_pct = 81;
  bit  recv_hold = 1'b0;
  int  errors = 0;
  int  results_seen = 0;
  int  zero_seen = 0;
  longint cycles = 0;

  function automatic logic [63:0] series_exp_neg(logic [63:0] z);
    logic signed [63:0] acc;
    logic [63:0] term;
    acc = 64'sd1073741824;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * z) >> 30) / n;
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  function automatic logic [63:0] pow2_neg(logic [63:0] v);
    return series_exp_neg((v * LN2 + (64'd1 << (RBITS - 1))) >> RBITS);
  endfunction

  function automatic gauss_result_t predict_gaussian(logic [31:0] xw);
    gauss_result_t res;
    longint d, prod, y;
    logic [63:0] m, r, t, u, k, f, p, sh, e, mag;
    e = 0;
    if (wid_q == 0) begin
      res.value_y = '0;
      res.width_zero = 1'b1;
      return res;
    end
    d = longint'($signed(xw)) - longint'(ctr_q);
    m = (d < 0) ? -d : d;
    if (m < ({32'd0, wid_q} << 3)) begin
      r = (m << RBITS) / wid_q;
      t = (r * r) >> (RBITS + 1);
      u = (t * LOG2E + (64'd1 << 29)) >> 30;
      k = u >> RBITS;
      f = u & ((64'd1 << RBITS) - 1);
      p = (pow2_lut[(f >> QBITS) & ((1 << TBITS) - 1)] *
           pow2_neg(f & ((64'd1 << QBITS) - 1)) + (64'd1 << 29)) >> 30;
      sh = 30 + k - FRAC;
      if (sh < 62) e = (p + (64'd1 << (sh - 1))) >> sh;
    end
    prod = longint'(amp_q) * longint'(e);
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
    y = (prod < 0) ? -longint'(mag) : longint'(mag);
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    res.value_y = y[31:0];
    res.width_zero = 1'b0;
    return res;
  endfunction

  // Driver: offer the head of the queue, drop it on acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        expected_results.push_back(predict_gaussian(sample.sample_x));
        void'(sample_words.pop_front());
      end
      // Hold a waiting word, otherwise offer the next one or idle
      if (!sample.valid || sample.ready) begin
        if (sample_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample.valid <= 1'b1;
          sample.sample_x <= sample_words[0];
        end else begin
          sample.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    gauss_result_t want;
    if (!rst) begin
      result.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      if (result.valid && result.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: value_y %h", result.value_y);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.width_zero) zero_seen <= zero_seen + 1;
          if (result.value_y !== want.value_y) begin
            $error("value_y expected %h actual %h", want.value_y, result.value_y);
            errors = errors + 1;
          end
          if (result.width_zero !== want.width_zero) begin
            $error("width_zero expected %b actual %b", want.width_zero, result.width_zero);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (sample_words.size() != 0 || sample.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // One register write, each in a clock cycle of its own
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_AMPLITUDE: amp_q = val;
      REG_CENTER:    ctr_q = val;
      REG_WIDTH:     wid_q = val;
      default: ;
    endcase
  endtask

  task automatic set_gaussian(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    write_reg(REG_AMPLITUDE, a);
    write_reg(REG_CENTER, b);
    write_reg(REG_WIDTH, c);
    @(posedge clk);
  endtask

  // Mostly samples near the peak, some in the tail, some anywhere
  function automatic logic [31:0] pick_sample();
    int sel;
    logic [31:0] span;
    sel = $urandom_range(9);
    span = (wid_q == 0) ? 32'h0001_0000 : wid_q;
    if (sel < 6) return ctr_q + $signed(($urandom() % ({1'b0, span} * 3 + 1)) -
                         ($urandom() % ({1'b0, span} * 3 + 1)));
    if (sel < 8) return ctr_q + ((sel == 6) ? span * 8 : -(span * 8)) +
                        $urandom_range(3) - 2;
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) sample_words.push_back(pick_sample());
    wait_drained();
  endtask

  initial begin
    logic [31:0] amps [6];
    logic [31:0] wids [6];
    amps = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_0000, 32'h0003_8000, 32'h0000_0001};
    wids = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001,
             32'h0000_4000, 32'h0020_0000, 32'h0000_0100};
    sample.valid = 1'b0;
    sample.sample_x = '0;
    result.ready = 1'b0;
    for (int j = 0; j < (1 << TBITS); j++) pow2_lut[j] = pow2_neg(64'(j) << QBITS);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes, tail edge, wide difference
    sample_words = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                     32'h0008_0000, 32'h0007_FFFF, 32'hFFF8_0000, 32'hFFF8_0001,
                     32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    wait_drained();
    set_gaussian(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    sample_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hC000_0000};
    wait_drained();
    set_gaussian(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    sample_words = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
    wait_drained();
    // Write to the unused index, must change nothing
    write_reg(reg_index_t'('1), 32'h1234_5678);
    set_gaussian(32'h0001_0000, 32'h0, 32'h0001_0000);
    sample_words = '{32'h0, 32'h0001_0000, 32'h7FFF_FFFF};
    wait_drained();

    // Random phases across settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      set_gaussian(ph == 0 ? amps[0] : $urandom(), $urandom(), wids[ph]);
      random_phase(60);
      set_gaussian(amps[ph], (ph % 2) ? 32'h0 : $urandom(), wids[ph]);
      if (ph == 2) begin send_idle_pct = 81; recv_idle_pct = 11; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_phase(165);
    end

    // Back-pressure: receiver holds off while sender keeps offering
    recv_hold = 1'b1;
    for (int i = 0; i < 150; i++) sample_words.push_back(pick_sample());
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();

    // Mixed idling, zero width again with random samples
    send_idle_pct = 30; recv_idle_pct = 30;
    set_gaussian($urandom(), $urandom(), 32'h0);
    random_phase(40);

    $display("Covered %0d result words (%0d with zero width) over extreme and random settings",
             results_seen, zero_seen);
    $display("under sender gaps, receiver stalls and a long output hold-off");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
